[rtl/mfh_pkg.sv]
// Shared types and constants for the message fragmenter with headers.
`timescale 1ns / 1ps

package mfh_pkg;

    localparam int DATA_W      = 8;
    localparam int LEN_W       = 16;
    localparam int TYPE_W      = 4;
    localparam int OFFSET_W    = 8;
    localparam int INDEX_W     = 9;
    localparam int HDR_BYTES   = 4;
    localparam int STEP_W      = 3;
    localparam int S_TDATA_W   = 32;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    localparam logic [DATA_W-1:0]  CONT_FLAG = 8'h10;
    localparam logic [INDEX_W-1:0] INDEX_MAX = 9'd511;
    localparam logic [STEP_W-1:0]  STEP_DATA = 3'd4;

    // One classified input item: optional header, then the payload byte.
    typedef struct packed {
        logic                             has_hdr;
        logic [HDR_BYTES-1:0][DATA_W-1:0] hdr;
        logic [DATA_W-1:0]                data;
        logic                             eof;
    } entry_t;

endpackage

[rtl/mfh_front.sv]
// Front end: accepts message bytes, tracks fragment state and builds headers.
`timescale 1ns / 1ps

module mfh_front #(
    parameter int PAYLOAD_BYTES = 251
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [mfh_pkg::DATA_W-1:0]  data_byte,
    input  logic [mfh_pkg::LEN_W-1:0]   message_length,
    input  logic [mfh_pkg::TYPE_W-1:0]  packet_type,
    input  logic                        q_full,
    output logic                        push,
    output mfh_pkg::entry_t             push_entry
);

    localparam logic [mfh_pkg::OFFSET_W:0] PAYLOAD_LIM = (mfh_pkg::OFFSET_W + 1)'(PAYLOAD_BYTES);

    logic [mfh_pkg::DATA_W-1:0]   seq_reg, seq_next;
    logic [mfh_pkg::LEN_W-1:0]    pos_reg, pos_next;
    logic [mfh_pkg::OFFSET_W-1:0] foff_reg, foff_next;
    logic [mfh_pkg::INDEX_W-1:0]  fidx_reg, fidx_next;
    logic [mfh_pkg::DATA_W-1:0]   fseq_reg, fseq_next;
    logic [mfh_pkg::LEN_W-1:0]    len_reg, len_next;
    logic [mfh_pkg::TYPE_W-1:0]   type_reg, type_next;

    logic                         start;
    logic [mfh_pkg::LEN_W-1:0]    cur_len;
    logic [mfh_pkg::TYPE_W-1:0]   cur_type;
    logic [mfh_pkg::OFFSET_W-1:0] cur_off;
    logic [mfh_pkg::INDEX_W-1:0]  cur_idx;
    logic                         opens_frag;
    logic                         leading;
    logic [mfh_pkg::LEN_W-1:0]    pos_inc;
    logic                         ends_msg;
    logic                         ends_frag;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        start      = (pos_reg == '0);
        cur_len    = start ? message_length : len_reg;
        cur_type   = start ? packet_type : type_reg;
        cur_off    = start ? '0 : foff_reg;
        cur_idx    = start ? '0 : fidx_reg;
        opens_frag = (cur_off == '0);
        leading    = (cur_idx == '0);
        pos_inc    = pos_reg + 1'b1;
        ends_msg   = (pos_inc == cur_len);
        ends_frag  = ends_msg || (({1'b0, cur_off} + 1'b1) >= PAYLOAD_LIM);

        push_entry.has_hdr = opens_frag;
        push_entry.hdr[0]  = seq_reg;
        push_entry.hdr[1]  = leading ? {{(mfh_pkg::DATA_W - mfh_pkg::TYPE_W){1'b0}}, cur_type}
                                     : (mfh_pkg::CONT_FLAG
                                        | {{(mfh_pkg::DATA_W - mfh_pkg::TYPE_W){1'b0}}, cur_type});
        push_entry.hdr[2]  = cur_len[mfh_pkg::DATA_W-1:0];
        push_entry.hdr[3]  = leading ? cur_len[mfh_pkg::LEN_W-1:mfh_pkg::DATA_W] : fseq_reg;
        push_entry.data    = data_byte;
        push_entry.eof     = ends_frag;

        seq_next  = seq_reg;
        pos_next  = pos_reg;
        foff_next = foff_reg;
        fidx_next = fidx_reg;
        fseq_next = fseq_reg;
        len_next  = len_reg;
        type_next = type_reg;

        if (push)
        begin
            len_next  = cur_len;
            type_next = cur_type;
            if (opens_frag)
            begin
                seq_next = seq_reg + 1'b1;
                if (leading)
                begin
                    fseq_next = seq_reg;
                end
            end
            if (ends_msg)
            begin
                pos_next  = '0;
                foff_next = '0;
                fidx_next = '0;
            end
            else
            begin
                pos_next = pos_inc;
                if (ends_frag)
                begin
                    foff_next = '0;
                    fidx_next = (cur_idx < mfh_pkg::INDEX_MAX) ? cur_idx + 1'b1 : cur_idx;
                end
                else
                begin
                    foff_next = cur_off + 1'b1;
                    fidx_next = cur_idx;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg  <= '0;
            pos_reg  <= '0;
            foff_reg <= '0;
            fidx_reg <= '0;
            fseq_reg <= '0;
            len_reg  <= '0;
            type_reg <= '0;
        end
        else
        begin
            seq_reg  <= seq_next;
            pos_reg  <= pos_next;
            foff_reg <= foff_next;
            fidx_reg <= fidx_next;
            fseq_reg <= fseq_next;
            len_reg  <= len_next;
            type_reg <= type_next;
        end
    end

endmodule

[rtl/mfh_queue.sv]
// Small register queue of classified items between the front and back ends.
`timescale 1ns / 1ps

module mfh_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mfh_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output mfh_pkg::entry_t head
);

    mfh_pkg::entry_t slots_reg [mfh_pkg::QUEUE_DEPTH];

    logic [mfh_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [mfh_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [mfh_pkg::QUEUE_AW:0]   count_reg, count_next;

    assign full       = (count_reg == (mfh_pkg::QUEUE_AW + 1)'(mfh_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + {{mfh_pkg::QUEUE_AW{1'b0}}, push}
                                - {{mfh_pkg::QUEUE_AW{1'b0}}, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/mfh_back.sv]
// Back end: serializes header and payload bytes into the registered output.
`timescale 1ns / 1ps

module mfh_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       head_valid,
    input  mfh_pkg::entry_t            head,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [mfh_pkg::DATA_W-1:0] out_byte,
    output logic                       end_of_fragment,
    output logic                       last_of_run
);

    logic [mfh_pkg::STEP_W-1:0] step_reg, step_next;
    logic                       valid_reg, valid_next;
    logic [mfh_pkg::DATA_W-1:0] byte_reg, byte_next;
    logic                       eof_reg, eof_next;
    logic                       last_reg, last_next;

    logic                       load;
    logic                       is_data;

    always_comb
    begin
        load    = head_valid && (!valid_reg || out_ready);
        is_data = !head.has_hdr || (step_reg == mfh_pkg::STEP_DATA);
        pop     = load && is_data;

        valid_next = valid_reg;
        byte_next  = byte_reg;
        eof_next   = eof_reg;
        last_next  = last_reg;
        step_next  = step_reg;

        if (load)
        begin
            valid_next = 1'b1;
            if (is_data)
            begin
                byte_next = head.data;
                eof_next  = head.eof;
                last_next = 1'b1;
                step_next = '0;
            end
            else
            begin
                byte_next = head.hdr[step_reg[1:0]];
                eof_next  = 1'b0;
                last_next = 1'b0;
                step_next = step_reg + 1'b1;
            end
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        eof_reg  <= eof_next;
        last_reg <= last_next;
    end

    assign out_valid       = valid_reg;
    assign out_byte        = byte_reg;
    assign end_of_fragment = eof_reg;
    assign last_of_run     = last_reg;

endmodule

[rtl/message_fragmenter_with_headers_core.sv]
// Top level of the message fragmenter: front end, item queue and byte serializer.
`timescale 1ns / 1ps

// Message bytes enter one per beat; the length and packet type are taken from the
// first byte of each message. Every PAYLOAD_BYTES payload bytes (and at the start of
// each message) a four-byte header goes out ahead of the payload byte: sequence number,
// type with continuation flag in bit 4, length low byte, then length high byte on the
// leading fragment or the leading fragment's sequence number on later ones. The output
// moves one byte per cycle while m_axis_tready is high; an input byte that opens a
// fragment yields four header bytes and its payload byte, any other byte just its
// payload byte. The input side takes a byte every cycle while the four-entry queue
// between the front end and the output serializer has room; the serializer's single
// output port sets the sustained rate. tlast marks the payload byte that ends a
// fragment; tuser is high on the payload byte, the last beat caused by each input byte.

module message_fragmenter_with_headers_core #(
    parameter int PAYLOAD_BYTES = 251
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // data_byte[7:0], message_length[23:8], packet_type[27:24], zero[31:28]
    input  logic [mfh_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_byte[7:0]
    output logic [mfh_pkg::DATA_W-1:0]    m_axis_tdata,
    // end_of_fragment
    output logic                          m_axis_tlast,
    // last_of_run[0]
    output logic                          m_axis_tuser
);

    logic            push;
    logic            q_full;
    logic            pop;
    logic            head_valid;
    mfh_pkg::entry_t push_entry;
    mfh_pkg::entry_t head;

    mfh_front #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .data_byte      (s_axis_tdata[7:0]),
        .message_length (s_axis_tdata[23:8]),
        .packet_type    (s_axis_tdata[27:24]),
        .q_full         (q_full),
        .push           (push),
        .push_entry     (push_entry)
    );

    mfh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    mfh_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (head_valid),
        .head            (head),
        .pop             (pop),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_byte        (m_axis_tdata),
        .end_of_fragment (m_axis_tlast),
        .last_of_run     (m_axis_tuser)
    );

    // A fragment can only end on a payload byte, never inside a header.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
        else $error("end of fragment flagged on a header beat");

    // The serializer only retires an item that the queue actually holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue popped while empty");

    // A full queue must hold off the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !push)
        else $error("item pushed into a full queue");

endmodule

[bench/message_fragmenter_with_headers_checker.sv]
// Checker for the message fragmenter: predicts header and payload beats and compares them.
`timescale 1ns / 1ps

module message_fragmenter_with_headers_checker #(
    parameter int PAYLOAD_BYTES = 251
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    // data_byte[7:0], message_length[23:8], packet_type[27:24], zero[31:28]
    input  logic [mfh_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_byte[7:0]
    input  logic [mfh_pkg::DATA_W-1:0]    m_axis_tdata,
    input  logic                          m_axis_tlast,
    input  logic                          m_axis_tuser,
    output int                            mismatches,
    output int                            beats_owed
);

    typedef struct packed {
        logic [mfh_pkg::DATA_W-1:0] value;
        logic                       frag_end;
        logic                       run_end;
    } out_beat_t;

    out_beat_t frag_beats[$];
    out_beat_t got;
    out_beat_t want;
    int        fail_tally;

    logic [mfh_pkg::DATA_W-1:0]   seq_ctr;
    logic [mfh_pkg::LEN_W-1:0]    byte_pos;
    logic [mfh_pkg::OFFSET_W-1:0] frag_off;
    logic [mfh_pkg::INDEX_W-1:0]  frag_idx;
    logic [mfh_pkg::DATA_W-1:0]   lead_seq;
    logic [mfh_pkg::LEN_W-1:0]    msg_len;
    logic [mfh_pkg::TYPE_W-1:0]   msg_type;

    task automatic push_beat(input logic [mfh_pkg::DATA_W-1:0] value, input logic frag_end,
                             input logic run_end);
        out_beat_t b;
        b.value    = value;
        b.frag_end = frag_end;
        b.run_end  = run_end;
        frag_beats.push_back(b);
    endtask

    // Works out the beats caused by one accepted input byte and advances the state.
    task automatic fragment_byte(input logic [mfh_pkg::S_TDATA_W-1:0] word);
        logic [mfh_pkg::DATA_W-1:0] type_byte;
        logic [mfh_pkg::DATA_W-1:0] tail_byte;
        logic [mfh_pkg::LEN_W-1:0]  next_pos;
        logic                       msg_done;
        logic                       frag_done;
        if (byte_pos == '0)
        begin
            msg_len  = word[mfh_pkg::DATA_W +: mfh_pkg::LEN_W];
            msg_type = word[mfh_pkg::DATA_W+mfh_pkg::LEN_W +: mfh_pkg::TYPE_W];
            frag_idx = '0;
            frag_off = '0;
        end
        if (frag_off == '0)
        begin
            if (frag_idx == '0)
            begin
                lead_seq  = seq_ctr;
                type_byte = {{(mfh_pkg::DATA_W-mfh_pkg::TYPE_W){1'b0}}, msg_type};
                tail_byte = msg_len[mfh_pkg::LEN_W-1:mfh_pkg::DATA_W];
            end
            else
            begin
                type_byte = mfh_pkg::CONT_FLAG
                            | {{(mfh_pkg::DATA_W-mfh_pkg::TYPE_W){1'b0}}, msg_type};
                tail_byte = lead_seq;
            end
            push_beat(seq_ctr, 1'b0, 1'b0);
            push_beat(type_byte, 1'b0, 1'b0);
            push_beat(msg_len[mfh_pkg::DATA_W-1:0], 1'b0, 1'b0);
            push_beat(tail_byte, 1'b0, 1'b0);
            seq_ctr = seq_ctr + 1'b1;
        end
        // A zero length wraps around here, so it stands for a full 65536-byte message.
        next_pos  = byte_pos + 1'b1;
        msg_done  = (next_pos == msg_len);
        frag_done = msg_done || (int'(frag_off) + 1 >= PAYLOAD_BYTES);
        push_beat(word[mfh_pkg::DATA_W-1:0], frag_done, 1'b1);
        if (msg_done)
        begin
            byte_pos = '0;
            frag_off = '0;
            frag_idx = '0;
        end
        else
        begin
            byte_pos = next_pos;
            if (frag_done)
            begin
                frag_off = '0;
                if (frag_idx < mfh_pkg::INDEX_MAX)
                    frag_idx = frag_idx + 1'b1;
            end
            else
            begin
                frag_off = frag_off + 1'b1;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_ctr    = '0;
            byte_pos   = '0;
            frag_off   = '0;
            frag_idx   = '0;
            lead_seq   = '0;
            msg_len    = '0;
            msg_type   = '0;
            fail_tally = 0;
            frag_beats.delete();
            mismatches <= 0;
            beats_owed <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                fragment_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata, m_axis_tlast, m_axis_tuser};
                if (frag_beats.size() == 0)
                begin
                    $display("%0t: unexpected beat: expected none, actual %h/%b/%b",
                             $time, got.value, got.frag_end, got.run_end);
                    fail_tally++;
                end
                else
                begin
                    want = frag_beats.pop_front();
                    if (got.value !== want.value || got.frag_end !== want.frag_end ||
                        got.run_end !== want.run_end)
                    begin
                        $display("%0t: beat mismatch: expected %h/%b/%b, actual %h/%b/%b",
                                 $time, want.value, want.frag_end, want.run_end,
                                 got.value, got.frag_end, got.run_end);
                        fail_tally++;
                    end
                end
            end
            mismatches <= fail_tally;
            beats_owed <= frag_beats.size();
        end
    end

endmodule

[bench/message_fragmenter_with_headers_core_tb.sv]
// Testbench top for the message fragmenter: clock, reset, stimulus, receiver pacing and verdict.
`timescale 1ns / 1ps

module message_fragmenter_with_headers_core_tb;

    localparam int PAYLOAD_BYTES  = 251;
    localparam int STALL_CYCLES   = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 20;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [mfh_pkg::S_TDATA_W-1:0]       s_axis_tdata = '0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [mfh_pkg::DATA_W-1:0]          m_axis_tdata;
    logic                                m_axis_tlast;
    logic                                m_axis_tuser;

    int   mismatches;
    int   beats_owed;
    int   tx_idle_pct = 32;
    int   rx_idle_pct = 86;
    int   items_sent = 0;
    int   quiet_cycles = 0;
    logic stall_req = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    message_fragmenter_with_headers_core #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    message_fragmenter_with_headers_checker #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser),
        .mismatches   (mismatches),
        .beats_owed   (beats_owed)
    );

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_byte(input logic [mfh_pkg::DATA_W-1:0] data,
                             input logic [mfh_pkg::LEN_W-1:0] len,
                             input logic [mfh_pkg::TYPE_W-1:0] ptype);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = {4'h0, 28'($urandom)};
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {4'h0, ptype, len, data};
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
        @(negedge clk);
    endtask

    // Sends n_bytes of a message; later bytes often carry junk length and type fields.
    task automatic send_message(input logic [mfh_pkg::LEN_W-1:0] len, input int n_bytes);
        logic [mfh_pkg::TYPE_W-1:0] ptype;
        logic [mfh_pkg::LEN_W-1:0]  len_field;
        logic [mfh_pkg::TYPE_W-1:0] type_field;
        ptype = (mfh_pkg::TYPE_W)'($urandom_range(0, 15));
        for (int i = 0; i < n_bytes; i++)
        begin
            len_field  = len;
            type_field = ptype;
            if (i != 0 && $urandom_range(0, 1) == 1)
            begin
                len_field  = (mfh_pkg::LEN_W)'($urandom);
                type_field = (mfh_pkg::TYPE_W)'($urandom);
            end
            send_byte((mfh_pkg::DATA_W)'($urandom_range(0, 255)), len_field, type_field);
        end
    endtask

    // Sends whole short messages until about n_items bytes have gone in.
    task automatic send_short_messages(input int n_items);
        int start_count;
        int short_len;
        start_count = items_sent;
        while (items_sent - start_count < n_items)
        begin
            if ($urandom_range(0, 3) != 0)
                short_len = $urandom_range(1, 3);
            else
                short_len = $urandom_range(4, 12);
            send_message((mfh_pkg::LEN_W)'(short_len), short_len);
        end
    endtask

    // Receiver pacing; the one long hold-off lets the input side back up.
    initial
    begin : rx_pacing
        int   hold_left;
        logic stall_used;
        hold_left  = 0;
        stall_used = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_req && !stall_used)
            begin
                hold_left  = STALL_CYCLES;
                stall_used = 1'b1;
            end
            if (hold_left > 0)
            begin
                m_axis_tready = 1'b0;
                hold_left--;
            end
            else
            begin
                m_axis_tready = ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("message_fragmenter_with_headers_core regression: fail");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Single-byte messages at the extremes of type and data.
        send_byte(8'h00, 16'd1, 4'h0);
        send_byte(8'hFF, 16'd1, 4'hF);
        // Fields on later bytes must be ignored, whether all ones or all zeros.
        send_byte(8'hA5, 16'd2, 4'h5);
        send_byte(8'h5A, 16'hFFFF, 4'hF);
        send_byte(8'h80, 16'd3, 4'hA);
        send_byte(8'h7F, 16'h0000, 4'h0);
        send_byte(8'h01, 16'h5555, 4'h6);
        for (int k = 0; k < 4; k++)
            send_byte(8'h01 << k, 16'd4, 4'h3);
        send_byte(8'hC3, 16'd1, 4'hC);

        // Slow receiver: short messages.
        tx_idle_pct = 32;
        rx_idle_pct = 86;
        send_short_messages(24);

        // Slow sender: one message just past a fragment, so its last byte opens
        // and closes a trailing fragment on its own.
        tx_idle_pct = 86;
        rx_idle_pct = 32;
        send_message((mfh_pkg::LEN_W)'(PAYLOAD_BYTES + 1), PAYLOAD_BYTES + 1);

        // Full speed, with one long receiver hold-off that fills the block.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        stall_req   = 1'b1;
        send_short_messages(18);

        // A zero length stands for 65536 bytes; only its opening bytes are sent.
        send_message(16'd0, 6);
        s_axis_tvalid = 1'b0;

        while (beats_owed != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("message_fragmenter_with_headers_core regression: pass");
        else
            $display("message_fragmenter_with_headers_core regression: fail");
        $finish;
    end

endmodule

[sim.f]
rtl/mfh_pkg.sv
rtl/mfh_front.sv
rtl/mfh_queue.sv
rtl/mfh_back.sv
rtl/message_fragmenter_with_headers_core.sv
bench/message_fragmenter_with_headers_checker.sv
bench/message_fragmenter_with_headers_core_tb.sv
